// ===== hw/rtl/hdcrc_pkg.sv =====
`timescale 1ns / 1ps

package hdcrc_pkg;

   localparam int unsigned LEN_WIDTH_DEFAULT = 16;

   localparam logic [7:0]  FLAG_BYTE = 8'h7E;
   localparam logic [7:0]  ESC_BYTE  = 8'h7D;
   localparam logic [7:0]  ESC_MASK  = 8'h20;
   localparam logic [15:0] CRC_INIT  = 16'hFFFF;
   localparam logic [15:0] CRC_XOROUT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY  = 16'h8408;
   localparam logic [15:0] CRC_GOOD_RESIDUE = 16'hF0B8;
   localparam logic [15:0] MAX_RAW_LEN_RESET = 16'hFFFF;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // Frame status codes.
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_CRC_ERR = 2'd1;
   localparam logic [1:0] ST_SHORT   = 2'd2;
   localparam logic [1:0] ST_LONG    = 2'd3;

   // One entry between front and back. For an end entry, pre_status is
   // ST_LONG or ST_SHORT when the length already decides, else ST_OK and the
   // back end checks the CRC against fcs.
   typedef struct packed {
      logic        is_end;
      logic [7:0]  data;
      logic [1:0]  pre_status;
      logic [15:0] fcs;
   } entry_type;

   // Reflected CRC-16/X.25 update over one byte.
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== hw/rtl/hdlc_deframer_crc16_unit.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake               Payload
// req      in         req_valid / req_stall   req_rx_byte
// rsp      out        rsp_valid / rsp_stall   rsp_data_byte, rsp_frame_end,
//                                             rsp_frame_status, rsp_payload_len
// csr      in         csr_wr_en               csr_wr_data (max_raw_len)
//
// One raw byte is taken every cycle while req_stall is low; the beat it causes, if any,
// is presented from the back end's output register: the front end writes the queue at
// the accepting edge and the back end registers the result, CRC byte step included, on pop.
// The CRC byte update in the back end is combinational, which sets that rate.
// Synchronous reset restores max_raw_len to 65535 and restarts the deframer;
// no clearing pass is needed.
// A two-entry queue lets the front keep taking bytes while rsp is stalled, and
// req_stall rises only once that queue is full.

module hdlc_deframer_crc16_unit
   import hdcrc_pkg::*;
#(
   parameter int unsigned LEN_WIDTH = LEN_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_frame_end,
   output logic [1:0]  rsp_frame_status,
   output logic [15:0] rsp_payload_len,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic      q_full, q_push, q_pop, q_not_empty;
   entry_type q_push_entry, q_pop_entry;

   hdcrc_front #(
      .LEN_WIDTH(LEN_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_entry(q_push_entry)
   );

   hdcrc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_entry(q_push_entry),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_entry (q_pop_entry)
   );

   hdcrc_back #(
      .LEN_WIDTH(LEN_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_not_empty     (q_not_empty),
      .q_entry         (q_pop_entry),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_frame_status(rsp_frame_status),
      .rsp_payload_len (rsp_payload_len)
   );

endmodule

// ===== hw/rtl/hdcrc_front.sv =====
`timescale 1ns / 1ps

module hdcrc_front
   import hdcrc_pkg::*;
#(
   parameter int unsigned LEN_WIDTH = LEN_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        q_full,
   output logic        q_push,
   output entry_type   q_push_entry
);

   localparam int unsigned CMP_W = (LEN_WIDTH > 16) ? LEN_WIDTH : 16;
   localparam logic [LEN_WIDTH-1:0] LEN_MAX = {LEN_WIDTH{1'b1}};

   logic [15:0]          max_raw_len_ff, max_raw_len_in;
   logic                 escape_ff, escape_in;
   logic [1:0]           dcount_ff, dcount_in;
   logic [7:0]           d0_ff, d0_in, d1_ff, d1_in;
   logic [LEN_WIDTH-1:0] raw_ff, raw_in;

   logic                 accept;
   logic                 is_flag;
   logic [7:0]           b;
   logic                 have_byte;
   logic [CMP_W-1:0]     raw_ext, max_ext;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;
   assign is_flag   = (req_rx_byte == FLAG_BYTE);
   assign raw_ext   = CMP_W'(raw_ff);
   assign max_ext   = CMP_W'(max_raw_len_ff);

   always_comb begin
      max_raw_len_in = csr_wr_en ? csr_wr_data : max_raw_len_ff;
      escape_in      = escape_ff;
      dcount_in      = dcount_ff;
      d0_in          = d0_ff;
      d1_in          = d1_ff;
      raw_in         = raw_ff;
      b              = req_rx_byte;
      have_byte      = 1'b0;
      q_push         = 1'b0;
      q_push_entry   = '0;

      if (accept) begin
         if (is_flag) begin
            q_push              = 1'b1;
            q_push_entry.is_end = 1'b1;
            q_push_entry.fcs    = {d1_ff, d0_ff};
            priority if (raw_ext >= max_ext) begin
               q_push_entry.pre_status = ST_LONG;
            end else if (raw_ff <= LEN_WIDTH'(2) || dcount_ff < 2'd2) begin
               q_push_entry.pre_status = ST_SHORT;
            end else begin
               q_push_entry.pre_status = ST_OK;
            end
            escape_in = 1'b0;
            dcount_in = 2'd0;
            raw_in    = '0;
         end else begin
            raw_in = (raw_ff == LEN_MAX) ? LEN_MAX : raw_ff + LEN_WIDTH'(1);
            priority if (escape_ff) begin
               b         = req_rx_byte ^ ESC_MASK;
               escape_in = 1'b0;
               have_byte = 1'b1;
            end else if (req_rx_byte == ESC_BYTE) begin
               escape_in = 1'b1;
            end else begin
               have_byte = 1'b1;
            end
         end
      end

      if (have_byte) begin
         priority if (dcount_ff == 2'd0) begin
            d0_in     = b;
            dcount_in = 2'd1;
         end else if (dcount_ff == 2'd1) begin
            d1_in     = b;
            dcount_in = 2'd2;
         end else begin
            // The older held byte leaves as payload.
            q_push            = 1'b1;
            q_push_entry.data = d0_ff;
            d0_in             = d1_ff;
            d1_in             = b;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_raw_len_ff <= MAX_RAW_LEN_RESET;
         escape_ff      <= 1'b0;
         dcount_ff      <= 2'd0;
         raw_ff         <= '0;
      end else begin
         max_raw_len_ff <= max_raw_len_in;
         escape_ff      <= escape_in;
         dcount_ff      <= dcount_in;
         raw_ff         <= raw_in;
      end
   end

   always_ff @(posedge clock) begin
      d0_ff <= d0_in;
      d1_ff <= d1_in;
   end

   a_flag_clears_escape: assert property (@(posedge clock) disable iff (reset)
      (accept && is_flag) |=> (!escape_ff && dcount_ff == 2'd0))
      else $error("delimiter did not restart the deframer");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("push into a full queue");

endmodule

// ===== hw/rtl/hdcrc_queue.sv =====
`timescale 1ns / 1ps

module hdcrc_queue
   import hdcrc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      not_empty,
   output entry_type pop_entry
);

   entry_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     count_ff, count_in;
   logic                  do_push, do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

endmodule

// ===== hw/rtl/hdcrc_back.sv =====
`timescale 1ns / 1ps

module hdcrc_back
   import hdcrc_pkg::*;
#(
   parameter int unsigned LEN_WIDTH = LEN_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_not_empty,
   input  entry_type   q_entry,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_frame_end,
   output logic [1:0]  rsp_frame_status,
   output logic [15:0] rsp_payload_len
);

   localparam logic [LEN_WIDTH-1:0] LEN_MAX = {LEN_WIDTH{1'b1}};

   logic [15:0]          crc_ff, crc_in;
   logic [LEN_WIDTH-1:0] pcount_ff, pcount_in;
   logic                 valid_ff, valid_in;
   logic [7:0]           data_ff, data_in;
   logic                 end_ff, end_in;
   logic [1:0]           status_ff, status_in;
   logic [15:0]          len_ff, len_in;
   logic [LEN_WIDTH+15:0] pcount_ext;

   assign q_pop      = q_not_empty && (!valid_ff || !rsp_stall);
   assign pcount_ext = {16'h0000, pcount_ff};

   always_comb begin
      crc_in    = crc_ff;
      pcount_in = pcount_ff;
      valid_in  = valid_ff && rsp_stall;
      data_in   = data_ff;
      end_in    = end_ff;
      status_in = status_ff;
      len_in    = len_ff;
      if (q_pop) begin
         valid_in = 1'b1;
         if (q_entry.is_end) begin
            data_in = 8'h00;
            end_in  = 1'b1;
            len_in  = pcount_ext[15:0];
            if (q_entry.pre_status != ST_OK) begin
               status_in = q_entry.pre_status;
            end else begin
               status_in = (q_entry.fcs == (crc_ff ^ CRC_XOROUT)) ? ST_OK : ST_CRC_ERR;
            end
            crc_in    = CRC_INIT;
            pcount_in = '0;
         end else begin
            data_in   = q_entry.data;
            end_in    = 1'b0;
            status_in = ST_OK;
            len_in    = 16'h0000;
            crc_in    = crc16_byte(crc_ff, q_entry.data);
            pcount_in = (pcount_ff == LEN_MAX) ? LEN_MAX : pcount_ff + LEN_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff    <= CRC_INIT;
         pcount_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         crc_ff    <= crc_in;
         pcount_ff <= pcount_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff   <= data_in;
      end_ff    <= end_in;
      status_ff <= status_in;
      len_ff    <= len_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_data_byte    = data_ff;
   assign rsp_frame_end    = end_ff;
   assign rsp_frame_status = status_ff;
   assign rsp_payload_len  = len_ff;

   a_end_restarts_crc: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_entry.is_end) |=> (crc_ff == CRC_INIT && pcount_ff == '0))
      else $error("frame end did not restart CRC and count");

   // A frame that passes its check leaves the well-known X.25 residue.
   a_ok_residue: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_entry.is_end && q_entry.pre_status == ST_OK && status_in == ST_OK)
      |-> (crc16_byte(crc16_byte(crc_ff, q_entry.fcs[7:0]), q_entry.fcs[15:8])
           == CRC_GOOD_RESIDUE))
      else $error("accepted frame without the good CRC residue");

endmodule
